[rtl/fbpa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed-size block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int MAX_BLOCKS   = 1024;
    localparam int HEADER_BYTES = 72;

    localparam int ADDR_W   = 32;
    localparam int REM_W    = 32;
    localparam int UNIT_W   = 17;
    localparam int ALIGN_W  = 13;
    localparam int STRIDE_W = 18;
    localparam int IDX_W    = $clog2(MAX_BLOCKS + 1);
    localparam int QBITS    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int STEP_W   = (QBITS > 1) ? $clog2(QBITS) : 1;
    localparam int CAP_W    = STRIDE_W + IDX_W;

    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(MAX_BLOCKS);

    typedef enum logic [1:0] {
        KIND_INIT  = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_FREE  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_BASE  = 2'd0,
        REG_SIZE  = 2'd1,
        REG_UNIT  = 2'd2,
        REG_ALIGN = 2'd3
    } reg_idx_t;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LAYOUT = 8'b0000_0010,
        S_MUL    = 8'b0000_0100,
        S_CHK    = 8'b0000_1000,
        S_DIV    = 8'b0001_0000,
        S_FIN    = 8'b0010_0000,
        S_LINK   = 8'b0100_0000,
        S_AREAD  = 8'b1000_0000
    } state_t;

endpackage
`default_nettype wire

[rtl/fixed_block_pool_allocator_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// Fixed-size block pool with a LIFO free list kept in a link RAM.
//
// Channel   Signals                                   Transaction
// command   start, busy, kind, block_address          start & !busy
// result    done, result_address, status, free_blocks done, one cycle
// config    psel, penable, pwrite, paddr, pwdata,     psel & penable & pwrite
//           prdata, pready
//
// Alloc: one link RAM read in S_AREAD. Other kinds and early rejects end in S_IDLE.
// Free: S_MUL, S_CHK, the 10-step restoring divider (S_DIV), S_FIN; a cap hit ends in S_CHK.
// Init: S_LAYOUT, then as Free, then N blocks linked one RAM write per cycle in S_LINK
// (no divider when the block count saturates). Reset clears control state only; the
// link RAM is not cleared. Results cannot be stalled; busy holds off new commands.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             start,
    output logic                            busy,
    input  wire  [1:0]                      kind,
    input  wire  [fbpa_pkg::ADDR_W-1:0]     block_address,
    output logic                            done,
    output logic [fbpa_pkg::ADDR_W-1:0]     result_address,
    output logic [1:0]                      status,
    output logic [fbpa_pkg::IDX_W-1:0]      free_blocks,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [3:0]                      paddr,
    input  wire  [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int IW = fbpa_pkg::IDX_W;
    localparam int QW = fbpa_pkg::QBITS;
    localparam int RW = fbpa_pkg::REM_W;
    localparam int SW = fbpa_pkg::STRIDE_W;

    // configuration
    logic [31:0]                   base_reg;
    logic [31:0]                   size_reg;
    logic [fbpa_pkg::UNIT_W-1:0]   unit_reg;
    logic [fbpa_pkg::ALIGN_W-1:0]  align_reg;
    logic                          cfg_we;
    fbpa_pkg::reg_idx_t            cfg_idx;

    // pool state
    fbpa_pkg::state_t              state_reg, state_next;
    logic [IW-1:0]                 head_reg, head_next;
    logic [IW-1:0]                 free_reg, free_next;
    logic [IW-1:0]                 total_reg, total_next;
    logic [31:0]                   first_reg, first_next;
    logic [SW-1:0]                 stride_reg, stride_next;
    logic                          done_reg, done_next;

    // datapath
    fbpa_pkg::kind_t               op_reg, op_next;
    fbpa_pkg::status_t             status_reg, status_next;
    logic [31:0]                   addr_out_reg, addr_out_next;
    logic [32:0]                   start_reg, start_next;
    logic [32:0]                   end_reg, end_next;
    logic [31:0]                   data_reg, data_next;
    logic [RW-1:0]                 rem_reg, rem_next;
    logic [SW-1:0]                 dsr_reg, dsr_next;
    logic [IW-1:0]                 lim_reg, lim_next;
    logic [fbpa_pkg::CAP_W-1:0]    cap_reg, cap_next;
    logic [QW-1:0]                 q_reg, q_next;
    logic [fbpa_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [IW-1:0]                 cnt_reg, cnt_next;
    logic [QW-1:0]                 lk_reg, lk_next;

    // link RAM
    logic                          mem_we;
    logic [QW-1:0]                 mem_waddr;
    logic [IW-1:0]                 mem_wdata;
    logic [IW-1:0]                 mem_rdata;

    // combinational helpers
    logic                          align_ok;
    logic [32:0]                   sum33;
    logic [32:0]                   start33;
    logic [32:0]                   end33;
    logic [33:0]                   amask34;
    logic [33:0]                   data34;
    logic [SW-1:0]                 amask18;
    logic [SW-1:0]                 bsize;
    logic [RW-1:0]                 trial;
    logic [IW-1:0]                 lk_inc;

    fbpa_ram #(
        .WIDTH (IW),
        .DEPTH (fbpa_pkg::MAX_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (head_reg[QW-1:0]),
        .rdata (mem_rdata)
    );

    // APB
    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite;
    assign cfg_idx = fbpa_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        unique case (cfg_idx)
            fbpa_pkg::REG_BASE:  prdata = base_reg;
            fbpa_pkg::REG_SIZE:  prdata = size_reg;
            fbpa_pkg::REG_UNIT:  prdata = 32'(unit_reg);
            fbpa_pkg::REG_ALIGN: prdata = 32'(align_reg);
        endcase
    end

    // layout arithmetic
    assign align_ok = (align_reg != '0) &&
                      ((align_reg & (align_reg - fbpa_pkg::ALIGN_W'(1))) == '0);
    assign sum33    = {1'b0, base_reg} + {1'b0, size_reg};
    assign start33  = ({1'b0, base_reg} + 33'd3) & ~33'd3;
    assign end33    = ((sum33[32] && (sum33[31:0] != '0)) ? {1'b1, 32'd0} : sum33)
                      & ~33'd3;
    assign amask34  = ~(34'(align_reg) - 34'd1);
    assign data34   = ({1'b0, start_reg} + 34'(fbpa_pkg::HEADER_BYTES)
                      + 34'(align_reg) - 34'd1) & amask34;
    assign amask18  = ~(SW'(align_reg) - SW'(1));
    assign bsize    = (SW'(unit_reg) + SW'(align_reg) - SW'(1)) & amask18;
    assign trial    = RW'(dsr_reg) << step_reg;
    assign lk_inc   = IW'(lk_reg) + IW'(1);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        free_next     = free_reg;
        total_next    = total_reg;
        first_next    = first_reg;
        stride_next   = stride_reg;
        done_next     = 1'b0;
        op_next       = op_reg;
        status_next   = status_reg;
        addr_out_next = addr_out_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        data_next     = data_reg;
        rem_next      = rem_reg;
        dsr_next      = dsr_reg;
        lim_next      = lim_reg;
        cap_next      = cap_reg;
        q_next        = q_reg;
        step_next     = step_reg;
        cnt_next      = cnt_reg;
        lk_next       = lk_reg;
        mem_we        = 1'b0;
        mem_waddr     = lk_reg;
        mem_wdata     = (lk_inc < cnt_reg) ? lk_inc : fbpa_pkg::NULL_IDX;

        unique case (state_reg)
            fbpa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next       = fbpa_pkg::kind_t'(kind);
                    addr_out_next = '0;
                    unique case (fbpa_pkg::kind_t'(kind))
                        fbpa_pkg::KIND_INIT:
                        begin
                            head_next   = fbpa_pkg::NULL_IDX;
                            free_next   = '0;
                            total_next  = '0;
                            first_next  = '0;
                            stride_next = '0;
                            start_next  = start33;
                            end_next    = end33;
                            if (!align_ok || (start33 >= end33))
                            begin
                                done_next   = 1'b1;
                                status_next = fbpa_pkg::ST_BAD;
                            end
                            else
                            begin
                                state_next = fbpa_pkg::S_LAYOUT;
                            end
                        end
                        fbpa_pkg::KIND_ALLOC:
                        begin
                            if ((free_reg == '0) || (head_reg >= fbpa_pkg::NULL_IDX) ||
                                (head_reg >= total_reg))
                            begin
                                done_next   = 1'b1;
                                status_next = fbpa_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = fbpa_pkg::S_AREAD;
                            end
                        end
                        fbpa_pkg::KIND_FREE:
                        begin
                            if ((block_address == '0) || (total_reg == '0) ||
                                (stride_reg == '0) || (free_reg >= total_reg) ||
                                (block_address < first_reg))
                            begin
                                done_next   = 1'b1;
                                status_next = fbpa_pkg::ST_BAD;
                            end
                            else
                            begin
                                rem_next   = RW'(block_address - first_reg);
                                dsr_next   = stride_reg;
                                lim_next   = total_reg;
                                state_next = fbpa_pkg::S_MUL;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = fbpa_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            fbpa_pkg::S_LAYOUT:
            begin
                if ((data34 >= {1'b0, end_reg}) || (bsize == '0))
                begin
                    done_next   = 1'b1;
                    status_next = fbpa_pkg::ST_BAD;
                    state_next  = fbpa_pkg::S_IDLE;
                end
                else
                begin
                    rem_next   = RW'(end_reg - data34[32:0]);
                    dsr_next   = bsize;
                    lim_next   = IW'(fbpa_pkg::MAX_BLOCKS);
                    data_next  = data34[31:0];
                    state_next = fbpa_pkg::S_MUL;
                end
            end
            fbpa_pkg::S_MUL:
            begin
                cap_next   = dsr_reg * lim_reg;
                q_next     = '0;
                step_next  = fbpa_pkg::STEP_W'(QW - 1);
                state_next = fbpa_pkg::S_CHK;
            end
            fbpa_pkg::S_CHK:
            begin
                // quotient would reach the limit
                if (rem_reg >= RW'(cap_reg))
                begin
                    if (op_reg == fbpa_pkg::KIND_INIT)
                    begin
                        cnt_next   = IW'(fbpa_pkg::MAX_BLOCKS);
                        lk_next    = '0;
                        state_next = fbpa_pkg::S_LINK;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = fbpa_pkg::ST_BAD;
                        state_next  = fbpa_pkg::S_IDLE;
                    end
                end
                else
                begin
                    state_next = fbpa_pkg::S_DIV;
                end
            end
            fbpa_pkg::S_DIV:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next         = rem_reg - trial;
                    q_next[step_reg] = 1'b1;
                end
                if (step_reg == '0)
                begin
                    state_next = fbpa_pkg::S_FIN;
                end
                else
                begin
                    step_next = step_reg - fbpa_pkg::STEP_W'(1);
                end
            end
            fbpa_pkg::S_FIN:
            begin
                if (op_reg == fbpa_pkg::KIND_INIT)
                begin
                    if (q_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = fbpa_pkg::ST_BAD;
                        state_next  = fbpa_pkg::S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = IW'(q_reg);
                        lk_next    = '0;
                        state_next = fbpa_pkg::S_LINK;
                    end
                end
                else
                begin
                    state_next = fbpa_pkg::S_IDLE;
                    done_next  = 1'b1;
                    if (rem_reg != '0)
                    begin
                        status_next = fbpa_pkg::ST_BAD;
                    end
                    else
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = q_reg;
                        mem_wdata   = head_reg;
                        head_next   = IW'(q_reg);
                        free_next   = free_reg + IW'(1);
                        status_next = fbpa_pkg::ST_OK;
                    end
                end
            end
            fbpa_pkg::S_LINK:
            begin
                mem_we = 1'b1;
                if (lk_inc == cnt_reg)
                begin
                    head_next   = '0;
                    free_next   = cnt_reg;
                    total_next  = cnt_reg;
                    first_next  = data_reg;
                    stride_next = dsr_reg;
                    done_next   = 1'b1;
                    status_next = fbpa_pkg::ST_OK;
                    state_next  = fbpa_pkg::S_IDLE;
                end
                else
                begin
                    lk_next = lk_reg + QW'(1);
                end
            end
            fbpa_pkg::S_AREAD:
            begin
                addr_out_next = first_reg + 32'(head_reg * stride_reg);
                head_next     = mem_rdata;
                free_next     = free_reg - IW'(1);
                done_next     = 1'b1;
                status_next   = fbpa_pkg::ST_OK;
                state_next    = fbpa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = fbpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= fbpa_pkg::S_IDLE;
            head_reg   <= fbpa_pkg::NULL_IDX;
            free_reg   <= '0;
            total_reg  <= '0;
            first_reg  <= '0;
            stride_reg <= '0;
            done_reg   <= 1'b0;
            base_reg   <= '0;
            size_reg   <= '0;
            unit_reg   <= fbpa_pkg::UNIT_W'(4);
            align_reg  <= fbpa_pkg::ALIGN_W'(4);
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            free_reg   <= free_next;
            total_reg  <= total_next;
            first_reg  <= first_next;
            stride_reg <= stride_next;
            done_reg   <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    fbpa_pkg::REG_BASE:  base_reg  <= pwdata;
                    fbpa_pkg::REG_SIZE:  size_reg  <= pwdata;
                    fbpa_pkg::REG_UNIT:  unit_reg  <= pwdata[fbpa_pkg::UNIT_W-1:0];
                    fbpa_pkg::REG_ALIGN: align_reg <= pwdata[fbpa_pkg::ALIGN_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        status_reg   <= status_next;
        addr_out_reg <= addr_out_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        data_reg     <= data_next;
        rem_reg      <= rem_next;
        dsr_reg      <= dsr_next;
        lim_reg      <= lim_next;
        cap_reg      <= cap_next;
        q_reg        <= q_next;
        step_reg     <= step_next;
        cnt_reg      <= cnt_next;
        lk_reg       <= lk_next;
    end

    assign busy           = (state_reg != fbpa_pkg::S_IDLE);
    assign done           = done_reg;
    assign result_address = addr_out_reg;
    assign status         = status_reg;
    assign free_blocks    = free_reg;

endmodule
`default_nettype wire

[rtl/fbpa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire  [$clog2(DEPTH)-1:0]  waddr,
    input  wire  [WIDTH-1:0]          wdata,
    input  wire  [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[tb/sv/tb_fixed_block_pool_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator_core
// Self-checking bench for the fixed-size block pool allocator. A short table
// of directed transactions covers reset state, layout extremes, address clamp
// at the top of memory, bad alignment, zero block size and every free reject.
// Random phases follow: each writes a new region layout over the config port,
// initializes the pool and runs mostly well-formed alloc/free traffic with
// some noise. Each result is checked against a cycle-free pool model or table row.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator_core;
    import fbpa_pkg::*;

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         GAP_MAX       = 12;
    localparam int         SETTLE_CYCLES = 24;
    localparam int         ITEM_TARGET   = 850;
    localparam longint     CYCLE_LIMIT   = 4_000_000;
    localparam int         N_DIRECTED    = 41;

    typedef enum logic { ROW_WRITE, ROW_CMD } row_op_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_t           status;
        logic [IDX_W-1:0]  blocks_free;
    } pool_result_t;

    typedef struct packed {
        row_op_t      op;
        logic [1:0]   code;
        logic [31:0]  value;
        logic         known;
        pool_result_t want;
    } row_t;

    localparam pool_result_t NO_RESULT = '{32'h0, ST_OK, '0};
    localparam pool_result_t EMPTY_RES = '{32'h0, ST_EMPTY, '0};
    localparam pool_result_t BAD_RES   = '{32'h0, ST_BAD, '0};

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          kind;
    logic [ADDR_W-1:0]   block_address;
    logic                done;
    logic [ADDR_W-1:0]   result_address;
    logic [1:0]          status;
    logic [IDX_W-1:0]    free_blocks;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [3:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // pool model state
    logic [31:0]         cfg_base;
    logic [31:0]         cfg_size;
    logic [UNIT_W-1:0]   cfg_unit;
    logic [ALIGN_W-1:0]  cfg_align;
    logic [IDX_W-1:0]    link_ram [MAX_BLOCKS];
    logic [IDX_W-1:0]    pool_head;
    logic [IDX_W-1:0]    pool_free;
    logic [IDX_W-1:0]    pool_count;
    logic [31:0]         pool_first;
    logic [31:0]         pool_stride;

    pool_result_t        expected_results[$];
    pool_result_t        oldest;
    logic [31:0]         held_blocks[$];
    int unsigned         fail_count;
    int unsigned         items_sent;
    longint              cycles;
    bit                  quiet;

    row_t directed_rows [N_DIRECTED] = '{
        '{ROW_CMD,   KIND_ALLOC,  32'h0,         1'b1, EMPTY_RES},
        '{ROW_CMD,   KIND_FREE,   32'h100,       1'b1, BAD_RES},
        '{ROW_CMD,   KIND_INIT,   32'h0,         1'b1, BAD_RES},
        '{ROW_CMD,   KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, BAD_RES},
        '{ROW_WRITE, REG_BASE,    32'h1001,      1'b0, NO_RESULT},
        '{ROW_WRITE, REG_SIZE,    32'h200,       1'b0, NO_RESULT},
        '{ROW_WRITE, REG_UNIT,    32'd5,         1'b0, NO_RESULT},
        '{ROW_WRITE, REG_ALIGN,   32'd8,         1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_INIT,   32'h0,         1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_ALLOC,  32'h0,         1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_ALLOC,  32'h0,         1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_FREE,   32'h1052,      1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_FREE,   32'h1048,      1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_FREE,   32'h1200,      1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_FREE,   32'h0,         1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_FREE,   32'h1050,      1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_FREE,   32'h1050,      1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_FREE,   32'h1058,      1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_ALLOC,  32'h0,         1'b0, NO_RESULT},
        '{ROW_WRITE, REG_BASE,    32'hFFFF_0000, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_SIZE,    32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_UNIT,    32'd1,         1'b0, NO_RESULT},
        '{ROW_WRITE, REG_ALIGN,   32'd1,         1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_INIT,   32'h0,         1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_ALLOC,  32'h0,         1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_FREE,   32'hFFFF_0048, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_ALIGN,   32'd3,         1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_INIT,   32'h0,         1'b1, BAD_RES},
        '{ROW_WRITE, REG_ALIGN,   32'd0,         1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_INIT,   32'h0,         1'b1, BAD_RES},
        '{ROW_WRITE, REG_ALIGN,   32'd4096,      1'b0, NO_RESULT},
        '{ROW_WRITE, REG_UNIT,    32'd0,         1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_INIT,   32'h0,         1'b1, BAD_RES},
        '{ROW_WRITE, REG_UNIT,    32'h1_0000,    1'b0, NO_RESULT},
        '{ROW_WRITE, REG_BASE,    32'h0,         1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_INIT,   32'h0,         1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_ALLOC,  32'h0,         1'b0, NO_RESULT},
        '{ROW_WRITE, REG_BASE,    32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ROW_WRITE, REG_SIZE,    32'd8,         1'b0, NO_RESULT},
        '{ROW_CMD,   KIND_INIT,   32'h0,         1'b1, BAD_RES},
        '{ROW_CMD,   KIND_ALLOC,  32'h0,         1'b1, EMPTY_RES}
    };

    fixed_block_pool_allocator_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .block_address  (block_address),
        .done           (done),
        .result_address (result_address),
        .status         (status),
        .free_blocks    (free_blocks),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one command to the pool model and returns its result.
    function automatic pool_result_t pool_step(input logic [1:0] k, input logic [31:0] a);
        pool_result_t r;
        logic [63:0]  al;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  data_b;
        logic [63:0]  bsize;
        logic [63:0]  cnt;
        logic [63:0]  off;
        logic [63:0]  idx;
        int           i;
        r.addr = '0;
        r.status = ST_BAD;
        if (k == KIND_INIT) begin
            pool_head   = NULL_IDX;
            pool_free   = '0;
            pool_count  = '0;
            pool_first  = '0;
            pool_stride = '0;
            al = 64'(cfg_align);
            lo = (64'(cfg_base) + 64'd3) & ~64'd3;
            hi = 64'(cfg_base) + 64'(cfg_size);
            if (hi > 64'h1_0000_0000)
                hi = 64'h1_0000_0000;
            hi = hi & ~64'd3;
            if (al != 0 && (al & (al - 1)) == 0 && lo < hi) begin
                data_b = (lo + 64'(HEADER_BYTES) + al - 1) & ~(al - 1);
                bsize  = (64'(cfg_unit) + al - 1) & ~(al - 1);
                if (data_b < hi && bsize != 0) begin
                    cnt = (hi - data_b) / bsize;
                    if (cnt > MAX_BLOCKS)
                        cnt = MAX_BLOCKS;
                    if (cnt != 0) begin
                        for (i = 0; i < int'(cnt); i++)
                            link_ram[i] = (i + 1 < int'(cnt)) ? IDX_W'(i + 1) : NULL_IDX;
                        pool_head   = '0;
                        pool_free   = IDX_W'(cnt);
                        pool_count  = IDX_W'(cnt);
                        pool_first  = data_b[31:0];
                        pool_stride = bsize[31:0];
                        r.status    = ST_OK;
                    end
                end
            end
        end else if (k == KIND_ALLOC) begin
            if (pool_free == 0 || pool_head >= NULL_IDX || pool_head >= pool_count) begin
                r.status = ST_EMPTY;
            end else begin
                r.addr    = pool_first + 32'(pool_head) * pool_stride;
                r.status  = ST_OK;
                pool_head = link_ram[pool_head];
                pool_free = pool_free - 1'b1;
            end
        end else if (k == KIND_FREE) begin
            if (a != 0 && pool_count != 0 && pool_stride != 0 && pool_free < pool_count
                && a >= pool_first) begin
                off = 64'(a - pool_first);
                if (off % 64'(pool_stride) == 0) begin
                    idx = off / 64'(pool_stride);
                    if (idx < 64'(pool_count)) begin
                        link_ram[idx] = pool_head;
                        pool_head     = IDX_W'(idx);
                        pool_free     = pool_free + 1'b1;
                        r.status      = ST_OK;
                    end
                end
            end
        end
        r.blocks_free = pool_free;
        return r;
    endfunction

    task automatic issue(input logic [1:0] k, input logic [31:0] a, input logic known,
                         input pool_result_t want, output pool_result_t r);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
        @(negedge clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        kind = k;
        block_address = a;
        do @(posedge clk); while (busy);
        r = pool_step(k, a);
        expected_results.push_back(known ? want : r);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register, then read it back.
    task automatic reg_write(input reg_idx_t r, input logic [31:0] v);
        logic [31:0] reg_value;
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {r, 2'b00};
        pwdata = v;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (r)
            REG_BASE:
            begin
                cfg_base = v;
                reg_value = cfg_base;
            end
            REG_SIZE:
            begin
                cfg_size = v;
                reg_value = cfg_size;
            end
            REG_UNIT:
            begin
                cfg_unit = v[UNIT_W-1:0];
                reg_value = 32'(cfg_unit);
            end
            default:
            begin
                cfg_align = v[ALIGN_W-1:0];
                reg_value = 32'(cfg_align);
            end
        endcase
        @(negedge clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== reg_value) begin
            $display("%0t: register %0d readback expected %h actual %h",
                     $time, r, reg_value, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic random_phase();
        logic [31:0]  al;
        logic [31:0]  al_eff;
        logic [31:0]  unit;
        logic [31:0]  base;
        logic [31:0]  size;
        logic [31:0]  bs;
        logic [31:0]  a;
        int           pick;
        int           j;
        int           ops;
        pool_result_t r;
        quiet = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 31);
        al = 32'd1 << $urandom_range(0, 12);
        if (pick == 0)
            al = 32'd0;
        else if (pick < 3)
            al = $urandom_range(1, 8191);
        pick = $urandom_range(0, 15);
        unit = (pick == 0) ? 32'h1_0000 :
               (pick == 1) ? $urandom_range(1, 65536) : $urandom_range(1, 64);
        pick = $urandom_range(0, 7);
        base = (pick == 0) ? $urandom_range(0, 255) :
               (pick == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 4095) : $urandom;
        al_eff = (al != 0 && (al & (al - 1)) == 0) ? al : 32'd4;
        bs = (unit + al_eff - 1) & ~(al_eff - 1);
        pick = $urandom_range(0, 11);
        if (pick == 0)
            size = $urandom;
        else if (pick == 1)
            size = $urandom_range(0, 96);
        else
            size = 32'd3 + 32'(HEADER_BYTES) + al_eff + bs * $urandom_range(1, 24)
                   + $urandom_range(0, 7);

        wait_idle();
        reg_write(REG_BASE, base);
        reg_write(REG_SIZE, size);
        reg_write(REG_UNIT, unit);
        reg_write(REG_ALIGN, al);
        issue(KIND_INIT, $urandom, 1'b0, NO_RESULT, r);
        held_blocks.delete();

        ops = $urandom_range(20, 60);
        repeat (ops)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45 && held_blocks.size() != 0) begin
                j = $urandom_range(0, held_blocks.size() - 1);
                a = held_blocks[j];
                held_blocks.delete(j);
                issue(KIND_FREE, a, 1'b0, NO_RESULT, r);
            end else if (pick < 85) begin
                issue(KIND_ALLOC, $urandom, 1'b0, NO_RESULT, r);
                if (r.status == ST_OK)
                    held_blocks.push_back(r.addr);
            end else begin
                j = (pool_count == 0) ? 0 : $urandom_range(0, pool_count - 1);
                a = pool_first + pool_stride * j;
                case ($urandom_range(0, 7))
                    0: issue(KIND_FREE, 32'h0, 1'b0, NO_RESULT, r);
                    1: issue(KIND_FREE, $urandom, 1'b0, NO_RESULT, r);
                    2:
                    begin
                        a = (pool_stride > 1) ? a + $urandom_range(1, pool_stride - 1)
                                              : pool_first - 1;
                        issue(KIND_FREE, a, 1'b0, NO_RESULT, r);
                    end
                    3: issue(KIND_UNUSED, $urandom, 1'b0, NO_RESULT, r);
                    4, 5: issue(KIND_FREE, a, 1'b0, NO_RESULT, r);  // free of any block, held or not
                    6:
                    begin
                        a = $urandom_range(0, 1) ? pool_first + pool_stride * pool_count
                                                 : pool_first - 4;
                        issue(KIND_FREE, a, 1'b0, NO_RESULT, r);
                    end
                    default:
                    begin
                        issue(KIND_INIT, $urandom, 1'b0, NO_RESULT, r);
                        held_blocks.delete();
                    end
                endcase
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected: addr %h status %0d free %0d",
                         $time, result_address, status, free_blocks);
                fail_count++;
            end else begin
                oldest = expected_results.pop_front();
                if (result_address !== oldest.addr) begin
                    $display("%0t: result_address expected %h actual %h",
                             $time, oldest.addr, result_address);
                    fail_count++;
                end
                if (status !== oldest.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, oldest.status, status);
                    fail_count++;
                end
                if (free_blocks !== oldest.blocks_free) begin
                    $display("%0t: free_blocks expected %0d actual %0d",
                             $time, oldest.blocks_free, free_blocks);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d transactions outstanding", $time,
                     expected_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        pool_result_t r;
        rst_n = 1'b0;
        start = 1'b0;
        kind = KIND_INIT;
        block_address = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_base = '0;
        cfg_size = '0;
        cfg_unit = UNIT_W'(4);
        cfg_align = ALIGN_W'(4);
        pool_head = NULL_IDX;
        pool_free = '0;
        pool_count = '0;
        pool_first = '0;
        pool_stride = '0;
        fail_count = 0;
        items_sent = 0;
        cycles = 0;
        quiet = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[n])
        begin
            if (directed_rows[n].op == ROW_WRITE) begin
                wait_idle();
                reg_write(reg_idx_t'(directed_rows[n].code), directed_rows[n].value);
            end else begin
                issue(directed_rows[n].code, directed_rows[n].value, directed_rows[n].known,
                      directed_rows[n].want, r);
            end
        end

        while (items_sent < ITEM_TARGET) random_phase();
        wait_idle();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
